/* rtl/core/msor_pkg.sv */
package msor_pkg;

	localparam int KIND_W = 3;
	localparam int REF_W  = 64;
	localparam int TAG_W  = 8;
	localparam int STAT_W = 2;
	localparam int LIVE_W = 7;

	localparam logic [KIND_W-1:0] KIND_TRACK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UNTRACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MARK     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SWEEP    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_TEARDOWN = 3'd5;

	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NULL      = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0] op_status;
		logic              newly_marked;
		logic              released_valid;
		logic [REF_W-1:0]  released_ref;
		logic [TAG_W-1:0]  released_tag;
		logic              last_of_run;
		logic [LIVE_W-1:0] live_total;
	} res_t;

endpackage

/* rtl/core/msor_req_if.sv */
interface msor_req_if import msor_pkg::*;;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [REF_W-1:0]  object_ref;
	logic [TAG_W-1:0]  destructor_tag;

	modport source (output valid, output kind, output object_ref, output destructor_tag,
		input ready);
	modport sink (input valid, input kind, input object_ref, input destructor_tag,
		output ready);
endinterface

/* rtl/core/msor_rsp_if.sv */
interface msor_rsp_if import msor_pkg::*;;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] op_status;
	logic              newly_marked;
	logic              released_valid;
	logic [REF_W-1:0]  released_ref;
	logic [TAG_W-1:0]  released_tag;
	logic              last_of_run;
	logic [LIVE_W-1:0] live_total;

	modport source (output valid, output op_status, output newly_marked,
		output released_valid, output released_ref, output released_tag,
		output last_of_run, output live_total, input ready);
	modport sink (input valid, input op_status, input newly_marked,
		input released_valid, input released_ref, input released_tag,
		input last_of_run, input live_total, output ready);
endinterface

/* rtl/core/msor_ram.sv */
module msor_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/msor_out_fifo.sv */
module msor_out_fifo import msor_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_vld,
	output logic  push_rdy,
	input  res_t  push_data,
	msor_rsp_if.source rsp
);

	res_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;
	res_t       head;

	assign push_rdy = (fill_q != 2'd2);
	assign do_push  = push_vld && push_rdy;
	assign do_pop   = rsp.valid && rsp.ready;
	assign head     = buf_q[rd_ptr_q];

	assign rsp.valid          = (fill_q != 2'd0);
	assign rsp.op_status      = head.op_status;
	assign rsp.newly_marked   = head.newly_marked;
	assign rsp.released_valid = head.released_valid;
	assign rsp.released_ref   = head.released_ref;
	assign rsp.released_tag   = head.released_tag;
	assign rsp.last_of_run    = head.last_of_run;
	assign rsp.live_total     = head.live_total;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/core/msor_engine.sv */
module msor_engine import msor_pkg::*; #(
	parameter int CAPACITY = 64,
	localparam int AW = $clog2(CAPACITY),
	localparam int CW = $clog2(CAPACITY + 1),
	localparam int DW = REF_W + TAG_W
) (
	input  logic          clk,
	input  logic          arst_n,
	msor_req_if.sink      req,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  logic [DW-1:0] rd_data,
	input  logic          rd_mark,
	output logic [AW-1:0] wr_addr,
	output logic          dwr_en,
	output logic [DW-1:0] dwr_data,
	output logic          mwr_en,
	output logic          mwr_data,
	output logic          push_vld,
	input  logic          push_rdy,
	output res_t          push_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CLEAR,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rd_ptr_q;
	logic [AW-1:0]     chk_idx_q;
	logic              chk_vld_q;
	logic [AW-1:0]     slot_q;
	logic [KIND_W-1:0] kind_q;
	logic [REF_W-1:0]  ref_q;
	logic [STAT_W-1:0] fin_stat_q;
	logic              fin_newly_q;
	res_t              pend_q;
	logic              pend_vld_q;

	logic [REF_W-1:0]  rd_ref;
	logic [TAG_W-1:0]  rd_tag;
	logic [CW-1:0]     last_w;
	logic              chk_is_last;
	logic              op_find;
	logic              is_sweep;
	logic              hit;
	logic              tear_emit;
	logic              emit;
	logic              stall;
	logic              more;
	logic              scan_end;
	logic              track_ok;
	res_t              rel_res;
	res_t              fin_res;

	assign rd_ref      = rd_data[DW-1:TAG_W];
	assign rd_tag      = rd_data[TAG_W-1:0];
	assign last_w      = cnt_q - CW'(1);
	assign chk_is_last = (CW'(chk_idx_q) == last_w);
	assign op_find     = (kind_q == KIND_UNTRACK) || (kind_q == KIND_MARK);
	assign is_sweep    = (kind_q == KIND_SWEEP);
	assign hit         = chk_vld_q && ((op_find && (rd_ref == ref_q)) || (is_sweep && !rd_mark));
	assign tear_emit   = chk_vld_q && (kind_q == KIND_TEARDOWN) && (rd_ref != '0)
		&& (rd_tag != '0);
	assign emit        = (hit && is_sweep) || tear_emit;
	assign stall       = emit && pend_vld_q && !push_rdy;
	assign more        = (rd_ptr_q < cnt_q);
	assign scan_end    = !chk_vld_q && !more;
	assign track_ok    = (req.kind == KIND_TRACK) && (req.object_ref != '0)
		&& (cnt_q != CW'(CAPACITY));
	assign req.ready   = (state_q == ST_IDLE);

	always_comb begin
		rel_res                = '0;
		rel_res.op_status      = STAT_DONE;
		rel_res.released_valid = 1'b1;
		rel_res.released_ref   = rd_ref;
		rel_res.released_tag   = rd_tag;
		rel_res.live_total     = is_sweep ? LIVE_W'(last_w) : '0;

		fin_res              = '0;
		fin_res.op_status    = fin_stat_q;
		fin_res.newly_marked = fin_newly_q;
		fin_res.last_of_run  = 1'b1;
		fin_res.live_total   = LIVE_W'(cnt_q);
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = rd_ptr_q[AW-1:0];
		wr_addr   = slot_q;
		dwr_en    = 1'b0;
		dwr_data  = rd_data;
		mwr_en    = 1'b0;
		mwr_data  = 1'b0;
		push_vld  = 1'b0;
		push_data = pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid && track_ok) begin
					wr_addr  = cnt_q[AW-1:0];
					dwr_en   = 1'b1;
					dwr_data = {req.object_ref, req.destructor_tag};
					mwr_en   = 1'b1;
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					if (hit && (kind_q == KIND_MARK)) begin
						wr_addr  = chk_idx_q;
						mwr_en   = 1'b1;
						mwr_data = 1'b1;
					end
					rd_en    = !hit && more;
					push_vld = emit && pend_vld_q;
				end
			end
			ST_CLEAR: begin
				wr_addr = rd_ptr_q[AW-1:0];
				mwr_en  = more;
			end
			ST_MOVE_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_w[AW-1:0];
			end
			ST_MOVE_WR: begin
				dwr_en   = 1'b1;
				mwr_en   = 1'b1;
				mwr_data = rd_mark;
			end
			ST_DONE: begin
				push_vld = 1'b1;
				if (pend_vld_q) begin
					push_data             = pend_q;
					push_data.last_of_run = 1'b1;
				end else begin
					push_data = fin_res;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rd_ptr_q    <= '0;
			chk_idx_q   <= '0;
			chk_vld_q   <= 1'b0;
			slot_q      <= '0;
			kind_q      <= KIND_TRACK;
			ref_q       <= '0;
			fin_stat_q  <= STAT_DONE;
			fin_newly_q <= 1'b0;
			pend_q      <= '0;
			pend_vld_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						kind_q      <= req.kind;
						ref_q       <= req.object_ref;
						rd_ptr_q    <= '0;
						chk_vld_q   <= 1'b0;
						pend_vld_q  <= 1'b0;
						fin_stat_q  <= STAT_DONE;
						fin_newly_q <= 1'b0;
						state_q     <= ST_DONE;
						if (((req.kind == KIND_TRACK) || (req.kind == KIND_UNTRACK)
							|| (req.kind == KIND_MARK)) && (req.object_ref == '0)) begin
							fin_stat_q <= STAT_NULL;
						end else if (req.kind == KIND_TRACK) begin
							if (track_ok) begin
								cnt_q <= cnt_q + CW'(1);
							end else begin
								fin_stat_q <= STAT_FULL;
							end
						end else if ((req.kind == KIND_UNTRACK) || (req.kind == KIND_MARK)
							|| (req.kind == KIND_SWEEP) || (req.kind == KIND_TEARDOWN)) begin
							state_q <= ST_SCAN;
						end else if (req.kind == KIND_CLEAR) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (emit) begin
							pend_q     <= rel_res;
							pend_vld_q <= 1'b1;
						end
						if (hit) begin
							chk_vld_q <= 1'b0;
							slot_q    <= chk_idx_q;
							if (kind_q == KIND_MARK) begin
								fin_newly_q <= !rd_mark;
								state_q     <= ST_DONE;
							end else if (chk_is_last) begin
								cnt_q    <= last_w;
								rd_ptr_q <= CW'(chk_idx_q);
								if (!is_sweep) begin
									state_q <= ST_DONE;
								end
							end else begin
								state_q <= ST_MOVE_RD;
							end
						end else if (more) begin
							chk_idx_q <= rd_ptr_q[AW-1:0];
							chk_vld_q <= 1'b1;
							rd_ptr_q  <= rd_ptr_q + CW'(1);
						end else begin
							chk_vld_q <= 1'b0;
							if (scan_end) begin
								if (op_find) begin
									fin_stat_q <= STAT_NOT_FOUND;
								end
								if (kind_q == KIND_TEARDOWN) begin
									cnt_q <= '0;
								end
								state_q <= ST_DONE;
							end
						end
					end
				end
				ST_CLEAR: begin
					if (more) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_MOVE_RD: begin
					state_q <= ST_MOVE_WR;
				end
				ST_MOVE_WR: begin
					cnt_q <= last_w;
					if (is_sweep) begin
						rd_ptr_q  <= CW'(slot_q);
						chk_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (push_rdy) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/mark_sweep_object_registry_core.sv */
// Mark-and-sweep object registry.
// req channel: one beat per operation (track, untrack, mark, clear marks,
// sweep, teardown). rsp channel: one or more beats per operation, the final
// one flagged by last_of_run; sweep gives one beat per released entry, and
// teardown one per entry with a nonzero destructor tag. Operations are taken
// one at a time; req.ready is high only while the engine is idle, and results
// queue in a two-beat output buffer. Untrack, mark, sweep and teardown scan
// the n live entries, bound by the single read port of the entry memories:
// one entry per cycle, except while rsp stalls or an entry is moved. Clear
// marks walks the n slots alike; track, null references and unused kinds do
// not scan. A search stops at its hit; one that misses reads all n entries.
// Untrack and sweep fill a released slot below the last with the last entry
// (a read state, then a write state); sweep then rescans that slot.
// Reset empties the registry and the output buffer; the entry memories are
// not cleared, since no slot at or above the live count is ever read.
// When rsp stalls, the output buffer fills and the engine holds where it is
// until a beat can be pushed; no result is dropped.
module mark_sweep_object_registry_core import msor_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	msor_req_if.sink   req,
	msor_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int DW = REF_W + TAG_W;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [DW-1:0] rd_data;
	logic [0:0]    rd_mark;
	logic [AW-1:0] wr_addr;
	logic          dwr_en;
	logic [DW-1:0] dwr_data;
	logic          mwr_en;
	logic          mwr_data;
	logic          push_vld;
	logic          push_rdy;
	res_t          push_data;

	msor_engine #(.CAPACITY(CAPACITY)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.rd_mark   (rd_mark[0]),
		.wr_addr   (wr_addr),
		.dwr_en    (dwr_en),
		.dwr_data  (dwr_data),
		.mwr_en    (mwr_en),
		.mwr_data  (mwr_data),
		.push_vld  (push_vld),
		.push_rdy  (push_rdy),
		.push_data (push_data)
	);

	msor_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_entry_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (dwr_en),
		.wr_addr (wr_addr),
		.wr_data (dwr_data)
	);

	msor_ram #(.WIDTH(1), .DEPTH(CAPACITY)) u_mark_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_mark),
		.wr_en   (mwr_en),
		.wr_addr (wr_addr),
		.wr_data (mwr_data)
	);

	msor_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (push_vld),
		.push_rdy  (push_rdy),
		.push_data (push_data),
		.rsp       (rsp)
	);

endmodule

/* dv/mark_sweep_object_registry_core_tb.sv */
`timescale 1ns / 1ps

module mark_sweep_object_registry_core_tb;
	import msor_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
	localparam int HOLD_CYCLES  = 400;
	localparam int OP_TOTAL     = 450;

	localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

	class registry_shadow;
		logic [REF_W-1:0] slot_ref  [CAPACITY];
		logic [TAG_W-1:0] slot_tag  [CAPACITY];
		bit               slot_mark [CAPACITY];
		int               live;
		res_t             pending [$];
		int               errors;

		function void add(logic [STAT_W-1:0] st, logic nm, logic rv, logic [REF_W-1:0] rr,
				logic [TAG_W-1:0] rt, int total);
			res_t e;
			e.op_status      = st;
			e.newly_marked   = nm;
			e.released_valid = rv;
			e.released_ref   = rr;
			e.released_tag   = rt;
			e.last_of_run    = 1'b0;
			e.live_total     = total[LIVE_W-1:0];
			pending.push_back(e);
		endfunction

		function void move_last(int slot);
			live--;
			slot_ref[slot]  = slot_ref[live];
			slot_tag[slot]  = slot_tag[live];
			slot_mark[slot] = slot_mark[live];
		endfunction

		function void note_op(logic [KIND_W-1:0] kind, logic [REF_W-1:0] oref,
				logic [TAG_W-1:0] tag);
			int   hit;
			int   i;
			int   first;
			res_t tail;
			first = pending.size();
			hit = -1;
			if ((kind == KIND_TRACK || kind == KIND_UNTRACK || kind == KIND_MARK) && oref == '0)
				add(STAT_NULL, 0, 0, '0, '0, live);
			else case (kind)
				KIND_TRACK: begin
					if (live >= CAPACITY)
						add(STAT_FULL, 0, 0, '0, '0, live);
					else begin
						slot_ref[live]  = oref;
						slot_tag[live]  = tag;
						slot_mark[live] = 1'b0;
						live++;
						add(STAT_DONE, 0, 0, '0, '0, live);
					end
				end
				KIND_UNTRACK, KIND_MARK: begin
					for (i = 0; i < live; i++)
						if (hit < 0 && slot_ref[i] == oref)
							hit = i;
					if (hit < 0)
						add(STAT_NOT_FOUND, 0, 0, '0, '0, live);
					else if (kind == KIND_UNTRACK) begin
						move_last(hit);
						add(STAT_DONE, 0, 0, '0, '0, live);
					end else begin
						add(STAT_DONE, !slot_mark[hit], 0, '0, '0, live);
						slot_mark[hit] = 1'b1;
					end
				end
				KIND_CLEAR: begin
					for (i = 0; i < live; i++)
						slot_mark[i] = 1'b0;
					add(STAT_DONE, 0, 0, '0, '0, live);
				end
				KIND_SWEEP: begin
					i = 0;
					while (i < live) begin
						if (slot_mark[i])
							i++;
						else begin
							// swap-with-last, then retest the same slot
							tail.released_ref = slot_ref[i];
							tail.released_tag = slot_tag[i];
							move_last(i);
							add(STAT_DONE, 0, 1, tail.released_ref, tail.released_tag, live);
						end
					end
				end
				KIND_TEARDOWN: begin
					for (i = 0; i < live; i++)
						if (slot_ref[i] != '0 && slot_tag[i] != '0)
							add(STAT_DONE, 0, 1, slot_ref[i], slot_tag[i], 0);
					live = 0;
				end
				default: add(STAT_DONE, 0, 0, '0, '0, live);
			endcase
			if (pending.size() == first)
				add(STAT_DONE, 0, 0, '0, '0, live);
			tail = pending.pop_back();
			tail.last_of_run = 1'b1;
			pending.push_back(tail);
		endfunction

		function void check_beat(res_t got);
			res_t want;
			if (pending.size() == 0) begin
				$error("result beat with nothing outstanding: %p", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.op_status !== want.op_status) begin
				$error("op_status: expected %0d, got %0d", want.op_status, got.op_status);
				errors++;
			end
			if (got.newly_marked !== want.newly_marked) begin
				$error("newly_marked: expected %0d, got %0d", want.newly_marked,
					got.newly_marked);
				errors++;
			end
			if (got.released_valid !== want.released_valid) begin
				$error("released_valid: expected %0d, got %0d", want.released_valid,
					got.released_valid);
				errors++;
			end
			if (got.released_ref !== want.released_ref) begin
				$error("released_ref: expected %h, got %h", want.released_ref,
					got.released_ref);
				errors++;
			end
			if (got.released_tag !== want.released_tag) begin
				$error("released_tag: expected %0d, got %0d", want.released_tag,
					got.released_tag);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", want.last_of_run,
					got.last_of_run);
				errors++;
			end
			if (got.live_total !== want.live_total) begin
				$error("live_total: expected %0d, got %0d", want.live_total, got.live_total);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	msor_req_if req_bus();
	msor_rsp_if rsp_bus();

	mark_sweep_object_registry_core #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	registry_shadow   shadow = new();
	int               snd_idle_pct;
	int               rcv_idle_pct;
	int               sent;
	int               cycles;
	int               hold_left;
	bit               hold_done;
	logic [REF_W-1:0] ref_pool [16];

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("mark_sweep_object_registry_core_tb failed");
			$finish;
		end
	end

	function automatic logic [REF_W-1:0] pick_ref();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll < 16)
			return ref_pool[roll];
		else if (roll < 19)
			return {$urandom, $urandom};
		return '0;
	endfunction

	function automatic logic [REF_W-1:0] live_ref();
		if (shadow.live > 0 && $urandom_range(0, 9) < 7)
			return shadow.slot_ref[$urandom_range(0, shadow.live - 1)];
		return pick_ref();
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(0, 3) == 0)
			return '0;
		return TAG_W'($urandom_range(1, 255));
	endfunction

	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [REF_W-1:0] oref,
			input logic [TAG_W-1:0] tag);
		int gap;
		gap = 0;
		while (gap < 12 && $urandom_range(0, 99) < snd_idle_pct)
			gap++;
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid          <= 1'b1;
		req_bus.kind           <= kind;
		req_bus.object_ref     <= oref;
		req_bus.destructor_tag <= tag;
		do @(posedge clk); while (!req_bus.ready);
		shadow.note_op(kind, oref, tag);
		sent++;
	endtask

	task automatic run_mix(input int n);
		int roll;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 38)
				send_op(KIND_TRACK, pick_ref(), pick_tag());
			else if (roll < 60)
				send_op(KIND_MARK, live_ref(), pick_tag());
			else if (roll < 72)
				send_op(KIND_UNTRACK, live_ref(), pick_tag());
			else if (roll < 78)
				send_op(KIND_CLEAR, pick_ref(), pick_tag());
			else if (roll < 88)
				send_op(KIND_SWEEP, pick_ref(), pick_tag());
			else if (roll < 91)
				send_op(KIND_TEARDOWN, pick_ref(), pick_tag());
			else if (roll < 94)
				send_op($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B, pick_ref(),
					pick_tag());
			else
				send_op(KIND_TRACK, {$urandom, $urandom}, pick_tag());
		end
	endtask

	// fill to capacity, overflow, mark some, then release in bulk
	task automatic fill_and_release();
		while (shadow.live < CAPACITY)
			send_op(KIND_TRACK, pick_ref(), pick_tag());
		repeat (2) send_op(KIND_TRACK, pick_ref(), pick_tag());
		repeat ($urandom_range(0, 20)) send_op(KIND_MARK, live_ref(), pick_tag());
		case ($urandom_range(0, 2))
			0: send_op(KIND_SWEEP, pick_ref(), pick_tag());
			1: send_op(KIND_TEARDOWN, pick_ref(), pick_tag());
			default: begin
				send_op(KIND_CLEAR, pick_ref(), pick_tag());
				send_op(KIND_SWEEP, pick_ref(), pick_tag());
			end
		endcase
	endtask

	initial begin
		res_t got;
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
				got.op_status      = rsp_bus.op_status;
				got.newly_marked   = rsp_bus.newly_marked;
				got.released_valid = rsp_bus.released_valid;
				got.released_ref   = rsp_bus.released_ref;
				got.released_tag   = rsp_bus.released_tag;
				got.last_of_run    = rsp_bus.last_of_run;
				got.live_total     = rsp_bus.live_total;
				shadow.check_beat(got);
			end
			if (!hold_done && sent >= 380) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else
				rsp_bus.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end
	end

	initial begin
		int ep;
		arst_n                 <= 1'b0;
		req_bus.valid          <= 1'b0;
		req_bus.kind           <= KIND_TRACK;
		req_bus.object_ref     <= '0;
		req_bus.destructor_tag <= '0;
		snd_idle_pct = 25;
		rcv_idle_pct = 50;
		foreach (ref_pool[i])
			ref_pool[i] = {$urandom, $urandom};
		ref_pool[0] = '1;
		ref_pool[1] = 64'd1;
		ref_pool[2] = {1'b1, 63'd0};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(KIND_TRACK, '0, 8'hFF);
		send_op(KIND_UNTRACK, '0, '0);
		send_op(KIND_MARK, '0, '0);
		send_op(KIND_SWEEP, '0, '0);
		send_op(KIND_TEARDOWN, '0, '0);
		send_op(KIND_CLEAR, '0, '0);
		send_op(KIND_TRACK, '1, 8'hFF);
		send_op(KIND_TRACK, 64'd1, 8'h00);
		send_op(KIND_TRACK, '1, 8'h5A);
		send_op(KIND_TRACK, {1'b1, 62'd0, 1'b1}, 8'hA5);
		send_op(KIND_MARK, '1, '0);
		send_op(KIND_MARK, '1, '0);
		send_op(KIND_MARK, 64'h1234, '0);
		send_op(KIND_UNTRACK, 64'h1234, '0);
		send_op(KIND_SPARE_A, '1, 8'hFF);
		send_op(KIND_SPARE_B, '0, '0);
		send_op(KIND_UNTRACK, 64'd1, '0);
		send_op(KIND_SWEEP, '0, '0);
		send_op(KIND_SWEEP, '0, '0);
		send_op(KIND_CLEAR, '0, '0);
		send_op(KIND_SWEEP, '0, '0);
		send_op(KIND_TRACK, 64'h55AA_55AA_55AA_55AA, 8'h00);
		send_op(KIND_TRACK, 64'hAA55_AA55_AA55_AA55, 8'h01);
		send_op(KIND_TEARDOWN, '0, '0);

		ep = 0;
		while (sent < OP_TOTAL) begin
			if (sent < 190) begin
				snd_idle_pct = 25;
				rcv_idle_pct = 50;
			end else if (sent < 350) begin
				snd_idle_pct = 50;
				rcv_idle_pct = 25;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			if (ep % 6 == 2 || $urandom_range(0, 11) == 0)
				fill_and_release();
			else
				run_mix(20);
			ep++;
		end
		req_bus.valid <= 1'b0;

		while (shadow.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("mark_sweep_object_registry_core_tb passed");
		else
			$display("mark_sweep_object_registry_core_tb failed");
		$finish;
	end

endmodule

/* mark_sweep_object_registry_core.f */
rtl/core/msor_pkg.sv
rtl/core/msor_req_if.sv
rtl/core/msor_rsp_if.sv
rtl/core/msor_ram.sv
rtl/core/msor_out_fifo.sv
rtl/core/msor_engine.sv
rtl/core/mark_sweep_object_registry_core.sv
dv/mark_sweep_object_registry_core_tb.sv
